/* design/ccs_pkg.sv */
// Shared types, character codes and the per-beat scan function of the comment stripper.
// No dependencies; used by ccs_scan, ccs_outbuf and comment_stripper_stream_top.
`timescale 1ns / 1ps

package ccs_pkg;

    // Character codes
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Scan modes
    localparam logic [1:0] MODE_TEXT    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_DROP    = 2'd2;

    // Lookahead held in text mode
    localparam logic [2:0] HELD_NONE      = 3'd0;
    localparam logic [2:0] HELD_SLASH     = 3'd1;
    localparam logic [2:0] HELD_LT        = 3'd2;
    localparam logic [2:0] HELD_LT_BANG   = 3'd3;
    localparam logic [2:0] HELD_LT_BANG_D = 3'd4;
    localparam logic [2:0] HELD_DASH      = 3'd5;

    // Closer progress inside a comment
    localparam logic [1:0] CL_NONE  = 2'd0;
    localparam logic [1:0] CL_STAR  = 2'd1;
    localparam logic [1:0] CL_DASH  = 2'd2;
    localparam logic [1:0] CL_DASH2 = 2'd3;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] held;
        logic [1:0] closer;
        logic       changed;
    } scan_state_t;

    // Results caused by one input beat
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    last;
        logic                    changed;
        logic                    empty;   // single closing result without a byte
    } scan_res_t;

    typedef struct packed {
        scan_state_t st;
        scan_res_t   res;
    } step_t;

    function automatic scan_res_t push_byte(scan_res_t r, logic [7:0] b);
        r.bytes[r.cnt[1:0]] = b;
        r.cnt = r.cnt + 3'd1;
        return r;
    endfunction

    // Scan a byte as fresh text with nothing held
    function automatic step_t scan_fresh(step_t s, logic [7:0] c);
        s.st.held = HELD_NONE;
        if (c == CH_SLASH) begin
            s.st.held = HELD_SLASH;
        end else if (c == CH_LT) begin
            s.st.held = HELD_LT;
        end else if (c == CH_DASH) begin
            s.st.held = HELD_DASH;
        end else if (c == CH_HASH) begin
            s.st.mode    = MODE_DROP;
            s.st.changed = 1'b1;
        end else begin
            s.res = push_byte(s.res, c);
        end
        return s;
    endfunction

    function automatic step_t open_comment(step_t s);
        s.st.mode    = MODE_COMMENT;
        s.st.held    = HELD_NONE;
        s.st.closer  = CL_NONE;
        s.st.changed = 1'b1;
        return s;
    endfunction

    // Full state update and result list for one accepted beat
    function automatic step_t scan_step(scan_state_t st, logic [7:0] c, logic is_last);
        step_t s;
        s     = '0;
        s.st  = st;
        case (st.mode)
            MODE_COMMENT: begin
                if ((c == CH_SLASH && st.closer == CL_STAR) ||
                    (c == CH_GT && st.closer == CL_DASH2)) begin
                    s.st.mode   = MODE_TEXT;
                    s.st.closer = CL_NONE;
                    s.st.held   = HELD_NONE;
                end else if (c == CH_STAR) begin
                    s.st.closer = CL_STAR;
                end else if (c == CH_DASH) begin
                    s.st.closer = (st.closer == CL_DASH || st.closer == CL_DASH2) ?
                                  CL_DASH2 : CL_DASH;
                end else begin
                    s.st.closer = CL_NONE;
                end
            end
            MODE_DROP: begin
                s.st = st;
            end
            default: begin
                case (st.held)
                    HELD_SLASH: begin
                        if (c == CH_STAR) begin
                            s = open_comment(s);
                        end else begin
                            s.res = push_byte(s.res, CH_SLASH);
                            s = scan_fresh(s, c);
                        end
                    end
                    HELD_LT: begin
                        if (c == CH_BANG) begin
                            s.st.held = HELD_LT_BANG;
                        end else begin
                            s.res = push_byte(s.res, CH_LT);
                            s = scan_fresh(s, c);
                        end
                    end
                    HELD_LT_BANG: begin
                        if (c == CH_DASH) begin
                            s.st.held = HELD_LT_BANG_D;
                        end else begin
                            s.res = push_byte(s.res, CH_LT);
                            s.res = push_byte(s.res, CH_BANG);
                            s = scan_fresh(s, c);
                        end
                    end
                    HELD_LT_BANG_D: begin
                        if (c == CH_DASH) begin
                            s = open_comment(s);
                        end else begin
                            s.res = push_byte(s.res, CH_LT);
                            s.res = push_byte(s.res, CH_BANG);
                            s.res = push_byte(s.res, CH_DASH);
                            s = scan_fresh(s, c);
                        end
                    end
                    HELD_DASH: begin
                        if (c == CH_DASH) begin
                            s.st.mode    = MODE_DROP;
                            s.st.held    = HELD_NONE;
                            s.st.changed = 1'b1;
                        end else begin
                            s.res = push_byte(s.res, CH_DASH);
                            s = scan_fresh(s, c);
                        end
                    end
                    default: begin
                        s = scan_fresh(s, c);
                    end
                endcase
            end
        endcase

        // End of string: close out and return to reset state
        if (is_last) begin
            if (s.st.mode == MODE_COMMENT) begin
                s.res = push_byte(s.res, CH_SPACE);
            end else if (s.st.mode != MODE_DROP) begin
                case (s.st.held)
                    HELD_SLASH:     s.res = push_byte(s.res, CH_SLASH);
                    HELD_LT:        s.res = push_byte(s.res, CH_LT);
                    HELD_LT_BANG: begin
                        s.res = push_byte(s.res, CH_LT);
                        s.res = push_byte(s.res, CH_BANG);
                    end
                    HELD_LT_BANG_D: begin
                        s.res = push_byte(s.res, CH_LT);
                        s.res = push_byte(s.res, CH_BANG);
                        s.res = push_byte(s.res, CH_DASH);
                    end
                    HELD_DASH:      s.res = push_byte(s.res, CH_DASH);
                    default:        s.res = s.res;
                endcase
            end
            if (s.res.cnt == 3'd0) begin
                s.res.cnt   = 3'd1;
                s.res.empty = 1'b1;
            end
            s.res.last    = 1'b1;
            s.res.changed = s.st.changed;
            s.st          = '0;
        end
        return s;
    endfunction

endpackage

/* design/ccs_scan.sv */
// Scanner state registers and the per-beat scan logic.
// Depends on ccs_pkg (scan_step function and types).
`timescale 1ns / 1ps

module ccs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                is_last,
    output ccs_pkg::scan_res_t  res
);

    ccs_pkg::scan_state_t state_reg;
    ccs_pkg::scan_state_t state_next;
    ccs_pkg::step_t       step;

    // Work out the results and next state of the incoming beat
    always_comb begin
        step       = ccs_pkg::scan_step(state_reg, data_byte, is_last);
        res        = step.res;
        state_next = accept ? step.st : state_reg;
    end

    // Advance the scanner state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/ccs_outbuf.sv */
// Result buffer: holds up to four result beats of one input beat and plays them out.
// Depends on ccs_pkg (scan_res_t).
`timescale 1ns / 1ps

module ccs_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ccs_pkg::scan_res_t res,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic [ccs_pkg::MAX_RES-1:0][7:0] bytes_reg;
    logic [2:0]                       cnt_reg, cnt_next;
    logic [1:0]                       rd_reg, rd_next;
    logic                             last_reg, changed_reg, empty_reg;
    logic                             take;
    logic                             final_beat;

    assign take       = m_tvalid && m_tready;
    assign final_beat = (cnt_reg == 3'd1);
    // Free for a new set once the last pending beat leaves this cycle
    assign can_load   = (cnt_reg == 3'd0) || (final_beat && m_tready);

    assign m_tvalid   = (cnt_reg != 3'd0);
    assign m_tdata    = empty_reg ? 8'h00 : bytes_reg[rd_reg];
    assign m_tlast    = last_reg && final_beat;
    assign m_tuser    = {changed_reg && m_tlast, !empty_reg};

    // Count and read pointer
    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load) begin
            cnt_next = res.cnt;
            rd_next  = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            rd_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    // Hold the payload of the loaded set
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg   <= res.bytes;
            last_reg    <= res.last;
            changed_reg <= res.changed;
            empty_reg   <= res.empty;
        end
    end

endmodule

/* design/comment_stripper_stream_top.sv */
// Top level of the comment stripper stream block.
// Depends on ccs_pkg, ccs_scan and ccs_outbuf.
`timescale 1ns / 1ps

// Strips slash-star and less-bang-dash-dash comments from a byte stream, and truncates a
// string at a double dash or hash. Each accepted input beat yields zero to four output
// beats, one per cycle while m_tready is high, from a four-entry result buffer; a new input
// beat is taken when the buffer is empty or as its last pending beat leaves, so plain text
// flows at one byte per cycle while m_tready is high; a flush of held lookahead bytes holds
// the input until the extra bytes have left. A string's final output beat has tlast set
// and the changed flag in tuser bit 1; tuser bit 0 low marks a closing beat with no byte.
module comment_stripper_stream_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_valid, [1] changed
    output logic       m_tlast    // out_last
);

    ccs_pkg::scan_res_t res;
    logic               can_load;
    logic               accept;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    ccs_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .is_last   (s_tlast),
        .res       (res)
    );

    ccs_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && (res.cnt != 3'd0)),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
